>>> rtl/npf_pkg.sv
// Shared types, constants and the control program of the next-prime finder.
package npf_pkg;

  // Default width of the start value.
  localparam int DEFAULT_VALUE_WIDTH = 16;

  // Program counter width and control program steps.
  localparam int PC_WIDTH = 4;
  typedef logic [PC_WIDTH-1:0] pc_t;

  localparam pc_t STEP_IDLE      = 4'd0;
  localparam pc_t STEP_TEST      = 4'd1;
  localparam pc_t STEP_CHECK     = 4'd2;
  localparam pc_t STEP_REM_INIT  = 4'd3;
  localparam pc_t STEP_REM_LOOP  = 4'd4;
  localparam pc_t STEP_DIV_TEST  = 4'd5;
  localparam pc_t STEP_NEXT_DIV  = 4'd6;
  localparam pc_t STEP_NEXT_CAND = 4'd7;
  localparam pc_t STEP_OUT_WAIT  = 4'd8;
  localparam pc_t STEP_EMIT      = 4'd9;

  // Datapath operations selected by a control word.
  typedef logic [2:0] op_t;
  localparam op_t OP_NONE      = 3'd0;
  localparam op_t OP_LOAD      = 3'd1;
  localparam op_t OP_INIT_DIV  = 3'd2;
  localparam op_t OP_INIT_REM  = 3'd3;
  localparam op_t OP_REM_STEP  = 3'd4;
  localparam op_t OP_NEXT_DIV  = 3'd5;
  localparam op_t OP_NEXT_CAND = 3'd6;
  localparam op_t OP_EMIT      = 3'd7;

  // Jump conditions; when the condition holds the sequencer jumps to the target.
  typedef logic [2:0] cond_t;
  localparam cond_t COND_NEVER     = 3'd0;
  localparam cond_t COND_ALWAYS    = 3'd1;
  localparam cond_t COND_NO_INPUT  = 3'd2;
  localparam cond_t COND_BELOW_TWO = 3'd3;
  localparam cond_t COND_SQ_ABOVE  = 3'd4;
  localparam cond_t COND_BITS_LEFT = 3'd5;
  localparam cond_t COND_REM_ZERO  = 3'd6;
  localparam cond_t COND_OUT_BUSY  = 3'd7;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctrl_word_t;

  // Control program: one word per step.
  function automatic ctrl_word_t program_rom(input pc_t pc);
    ctrl_word_t w;
    unique case (pc)
      STEP_IDLE:      w = '{OP_LOAD,      COND_NO_INPUT,  STEP_IDLE};
      STEP_TEST:      w = '{OP_INIT_DIV,  COND_BELOW_TWO, STEP_NEXT_CAND};
      STEP_CHECK:     w = '{OP_NONE,      COND_SQ_ABOVE,  STEP_OUT_WAIT};
      STEP_REM_INIT:  w = '{OP_INIT_REM,  COND_NEVER,     STEP_IDLE};
      STEP_REM_LOOP:  w = '{OP_REM_STEP,  COND_BITS_LEFT, STEP_REM_LOOP};
      STEP_DIV_TEST:  w = '{OP_NONE,      COND_REM_ZERO,  STEP_NEXT_CAND};
      STEP_NEXT_DIV:  w = '{OP_NEXT_DIV,  COND_ALWAYS,    STEP_CHECK};
      STEP_NEXT_CAND: w = '{OP_NEXT_CAND, COND_ALWAYS,    STEP_TEST};
      STEP_OUT_WAIT:  w = '{OP_NONE,      COND_OUT_BUSY,  STEP_OUT_WAIT};
      STEP_EMIT:      w = '{OP_EMIT,      COND_ALWAYS,    STEP_IDLE};
      default:        w = '{OP_NONE,      COND_ALWAYS,    STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/next_prime_finder.sv
// Top level of the next-prime finder: microcoded sequencer and trial-division datapath.
//
// Each request carries a start value; the block returns the smallest prime strictly
// greater than it (2 for a start of 0 or 1). Candidates are tested by trial division
// with divisors d = 2, 3, ... while d*d does not exceed the candidate. Each divisor
// test runs the bit-serial remainder loop, which handles one candidate bit per cycle;
// the test of a candidate stops at the first divisor found, and a request runs through
// all candidates up to the result, with steps for loading and emitting around them.
// One request is worked on at a time; a finished result waits in the output register
// while the next request is taken in.
module next_prime_finder #(
  parameter int VALUE_WIDTH = npf_pkg::DEFAULT_VALUE_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] start_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH:0]   prime_found
);
  import npf_pkg::*;

  localparam int CW = VALUE_WIDTH + 1;
  localparam int BW = $clog2(CW);

  pc_t             pc;
  pc_t             pc_next;
  ctrl_word_t      cw;
  logic            jump;
  logic [CW-1:0]   cand;
  logic [CW-1:0]   divisor;
  logic [CW:0]     square;
  logic [CW-1:0]   rem;
  logic [BW-1:0]   bit_cnt;
  logic [CW:0]     rem_shift;
  logic [CW:0]     rem_diff;

  // Fetch the control word of the current step.
  assign cw = program_rom(pc);

  // Requests are taken only in the idle step.
  assign in_stall = (pc != STEP_IDLE);

  // Evaluate the jump condition of the current step.
  always_comb begin
    unique case (cw.cond)
      COND_NEVER:     jump = 1'b0;
      COND_ALWAYS:    jump = 1'b1;
      COND_NO_INPUT:  jump = !in_valid;
      COND_BELOW_TWO: jump = (cand < CW'(2));
      COND_SQ_ABOVE:  jump = (square > {1'b0, cand});
      COND_BITS_LEFT: jump = (bit_cnt != '0);
      COND_REM_ZERO:  jump = (rem == '0);
      COND_OUT_BUSY:  jump = out_valid && out_stall;
      default:        jump = 1'b1;
    endcase
  end

  assign pc_next = jump ? cw.target : pc + pc_t'(1);

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // One restoring division step: bring in the next candidate bit, subtract if it fits.
  assign rem_shift = {rem, cand[bit_cnt]};
  assign rem_diff  = rem_shift - {1'b0, divisor};

  // Datapath registers driven by the control word.
  always_ff @(posedge clk) begin
    unique case (cw.op)
      OP_LOAD: begin
        cand <= {1'b0, start_value} + CW'(1);
      end
      OP_INIT_DIV: begin
        divisor <= CW'(2);
        square  <= (CW + 1)'(4);
      end
      OP_INIT_REM: begin
        rem     <= '0;
        bit_cnt <= BW'(CW - 1);
      end
      OP_REM_STEP: begin
        rem     <= (rem_shift >= {1'b0, divisor}) ? rem_diff[CW-1:0] : rem_shift[CW-1:0];
        bit_cnt <= bit_cnt - BW'(1);
      end
      OP_NEXT_DIV: begin
        divisor <= divisor + CW'(1);
        square  <= square + {divisor, 1'b0} + (CW + 1)'(1);
      end
      OP_NEXT_CAND: begin
        cand <= cand + CW'(1);
      end
      OP_EMIT: begin
        prime_found <= cand;
      end
      OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // Output register: set on emit, cleared when the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

`ifndef NO_ASSERTIONS
  // An accepted request moves the sequencer into the candidate test.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (pc == STEP_TEST))
    else $error("accepted request did not start a search");

  // The remainder is always reduced below the divisor after the division loop.
  a_rem_reduced: assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_DIV_TEST) |-> (rem < divisor))
    else $error("remainder not below divisor");

  // A result is never written over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (pc == STEP_EMIT) |-> !(out_valid && out_stall))
    else $error("result overwritten while stalled");

  // Every delivered result is at least two.
  a_result_min: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (prime_found >= CW'(2)))
    else $error("result below two");
`endif

endmodule
